FILE: design/twim_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package twim_pkg;

  // Sample and table geometry.
  localparam int SAMPLE_W    = 16;
  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int FRAC_W      = SAMPLE_W - 1;
  localparam int LOW_W       = SAMPLE_W - ADDR_W;

  // Register widths and reset values.
  localparam int CLIP_W    = 15;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = GAIN_W - 1;
  localparam logic [CLIP_W-1:0] CLIP_RESET = 15'd29491;
  localparam logic [GAIN_W-1:0] WET_RESET  = 16'd0;
  localparam logic [GAIN_W-1:0] DRY_RESET  = 16'd32768;

  // Configuration port.
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam int REG_W  = APB_AW - 2;
  localparam logic [REG_W-1:0] REG_CLIP = 2'd0;
  localparam logic [REG_W-1:0] REG_WET  = 2'd1;
  localparam logic [REG_W-1:0] REG_DRY  = 2'd2;

  // Input stream: tdata carries sample_in, entry_index, entry_value; tuser the command.
  localparam int S_DATA_RAW = SAMPLE_W + ADDR_W + SAMPLE_W;
  localparam int S_TDATA_W  = ((S_DATA_RAW + 7) / 8) * 8;
  localparam int IDX_LSB    = SAMPLE_W;
  localparam int VAL_LSB    = SAMPLE_W + ADDR_W;
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  typedef struct packed {
    logic [CLIP_W-1:0] clip;
    logic [GAIN_W-1:0] wet_gain;
    logic [GAIN_W-1:0] dry_gain;
  } cfg_t;

  // Handoff from the interpolator to the mixer.
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] wet;
    logic signed [SAMPLE_W-1:0] x;
  } wet_t;

endpackage

`default_nettype wire

FILE: design/twim_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module twim_regs import twim_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic             wr;
  logic [REG_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign reg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clip     <= CLIP_RESET;
      cfg.wet_gain <= WET_RESET;
      cfg.dry_gain <= DRY_RESET;
    end else if (wr) begin
      case (reg_idx)
        REG_CLIP: cfg.clip     <= pwdata[CLIP_W-1:0];
        REG_WET:  cfg.wet_gain <= pwdata[GAIN_W-1:0];
        REG_DRY:  cfg.dry_gain <= pwdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CLIP: prdata = {{(APB_DW-CLIP_W){1'b0}}, cfg.clip};
      REG_WET:  prdata = {{(APB_DW-GAIN_W){1'b0}}, cfg.wet_gain};
      REG_DRY:  prdata = {{(APB_DW-GAIN_W){1'b0}}, cfg.dry_gain};
      default:  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/twim_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Transfer table: one write port, two registered read ports.
module twim_table import twim_pkg::*; (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  logic [SAMPLE_W-1:0] wdata,
  input  logic                re,
  input  logic [ADDR_W-1:0]   raddr_a,
  input  logic [ADDR_W-1:0]   raddr_b,
  output logic [SAMPLE_W-1:0] rdata_a,
  output logic [SAMPLE_W-1:0] rdata_b
);

  logic [SAMPLE_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

FILE: design/twim_interp.sv
`timescale 1ns / 1ps
`default_nettype none

// Clip and address generation, then two stages of linear interpolation.
module twim_interp import twim_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [CLIP_W-1:0]          clip,
  input  logic                       in_valid,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       in_ready,
  output logic                       rd_en,
  output logic [ADDR_W-1:0]          raddr_a,
  output logic [ADDR_W-1:0]          raddr_b,
  input  logic [SAMPLE_W-1:0]        rdata_a,
  input  logic [SAMPLE_W-1:0]        rdata_b,
  output wet_t                       out,
  input  logic                       out_ready
);

  localparam int PROD_W = 2 * SAMPLE_W + 1;
  localparam int SH_W   = PROD_W - FRAC_W;

  logic signed [SAMPLE_W:0]   x_ext;
  logic signed [SAMPLE_W:0]   c_pos;
  logic signed [SAMPLE_W:0]   c_neg;
  logic signed [SAMPLE_W:0]   t;
  logic [SAMPLE_W-1:0]        u;
  logic [FRAC_W-1:0]          f;

  logic                       v1;
  logic [FRAC_W-1:0]          f1;
  logic signed [SAMPLE_W-1:0] x1;

  logic                       v2;
  logic signed [PROD_W-1:0]   prod2;
  logic signed [SAMPLE_W-1:0] a2;
  logic signed [SAMPLE_W-1:0] x2;

  logic signed [SAMPLE_W:0]   diff;
  logic signed [SH_W-1:0]     wet_sum;
  logic                       r2;
  logic                       r3;

  assign x_ext = {sample_in[SAMPLE_W-1], sample_in};
  assign c_pos = $signed({2'b00, clip});
  assign c_neg = -c_pos;

  always_comb begin
    if (x_ext >= c_pos) begin
      t = c_pos;
    end else if (x_ext <= c_neg) begin
      t = c_neg;
    end else begin
      t = x_ext;
    end
  end

  // Offsetting by half scale flips the sign bit; the top bits index the table
  // and the rest become the interpolation fraction.
  assign u       = {~t[SAMPLE_W-1], t[SAMPLE_W-2:0]};
  assign raddr_a = u[SAMPLE_W-1 -: ADDR_W];
  assign raddr_b = (raddr_a == ADDR_W'(TABLE_DEPTH - 1)) ? raddr_a : raddr_a + 1'b1;
  assign f       = {u[LOW_W-1:0], {(ADDR_W-1){1'b0}}};

  assign r3       = !out.valid || out_ready;
  assign r2       = !v2 || r3;
  assign in_ready = !v1 || r2;
  assign rd_en    = in_ready;

  // A table write is stored at its accept edge, before any later sample reads it, so no bypass.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      f1 <= f;
      x1 <= sample_in;
    end
  end

  assign diff = $signed({rdata_b[SAMPLE_W-1], rdata_b}) - $signed({rdata_a[SAMPLE_W-1], rdata_a});

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      prod2 <= diff * $signed({1'b0, f1});
      a2    <= $signed(rdata_a);
      x2    <= x1;
    end
  end

  // The interpolated value always lies between the two entries, so it fits.
  assign wet_sum = $signed({{(SH_W-SAMPLE_W){a2[SAMPLE_W-1]}}, a2})
                 + $signed(prod2[PROD_W-1:FRAC_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (r3) begin
      out.valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      out.wet <= $signed(wet_sum[SAMPLE_W-1:0]);
      out.x   <= x2;
    end
  end

endmodule

`default_nettype wire

FILE: design/twim_mix.sv
`timescale 1ns / 1ps
`default_nettype none

// Wet and dry gain products, then sum, scale and saturate into the output register.
module twim_mix import twim_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [GAIN_W-1:0]   wet_gain,
  input  logic [GAIN_W-1:0]   dry_gain,
  input  wet_t                in,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] shaped_sample
);

  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int MIX_W  = SUM_W - GAIN_FRAC;

  logic                     v4;
  logic signed [PROD_W-1:0] pw;
  logic signed [PROD_W-1:0] pd;
  logic signed [SUM_W-1:0]  sum;
  logic [MIX_W-1:0]         mix;
  logic [MIX_W-SAMPLE_W:0]  hi;
  logic [SAMPLE_W-1:0]      sat;
  logic                     r5;

  assign r5       = !out_valid || out_ready;
  assign in_ready = !v4 || r5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (in_ready) begin
      v4 <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      pw <= in.wet * $signed({1'b0, wet_gain});
      pd <= in.x * $signed({1'b0, dry_gain});
    end
  end

  assign sum = $signed({pw[PROD_W-1], pw}) + $signed({pd[PROD_W-1], pd});
  assign mix = sum[SUM_W-1:GAIN_FRAC];
  assign hi  = mix[MIX_W-1:SAMPLE_W-1];

  // In range when all bits above the sample's sign bit repeat it.
  always_comb begin
    if ((&hi) || !(|hi)) begin
      sat = mix[SAMPLE_W-1:0];
    end else if (mix[MIX_W-1]) begin
      sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (r5) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (r5) begin
      shaped_sample <= sat;
    end
  end

endmodule

`default_nettype wire

FILE: design/table_waveshaper_interp_mix_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Contents
// s_*       in         s_tvalid / s_tready       tuser: command, tdata: sample and table write
// m_*       out        m_tvalid / m_tready       tdata: shaped sample
// APB       in         psel, penable, pready     clip_level, wet_gain, dry_gain at 0x0, 0x4, 0x8
//
// One item is accepted per cycle unless a stall backs up to the input; a sample passes
// the table read, product, interpolated-value, gain product and output registers, a table write
// gives no result and is stored at its accept edge. The rate is set by the table RAM's
// two read ports, read once per sample. Reset clears the stage valid bits and loads the
// register defaults; the table is not cleared and must be loaded before samples are sent.
// Each stage advances when its successor is empty or moving, so bubbles close up
// and input is still taken while a result waits at the output if a stage is empty.
module table_waveshaper_interp_mix_unit import twim_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // sample_in, entry_index, entry_value, zero pad
  input  logic                 s_tuser,  // command
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [SAMPLE_W-1:0]  m_tdata,  // shaped_sample
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  cfg_t                cfg;
  wet_t                wet;
  logic                mix_ready;
  logic                s_fire;
  logic                tbl_we;
  logic                rd_en;
  logic [ADDR_W-1:0]   raddr_a;
  logic [ADDR_W-1:0]   raddr_b;
  logic [SAMPLE_W-1:0] rdata_a;
  logic [SAMPLE_W-1:0] rdata_b;

  assign s_fire = s_tvalid & s_tready;
  assign tbl_we = s_fire && (s_tuser == CMD_WRITE);

  twim_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  twim_table u_table (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (s_tdata[IDX_LSB +: ADDR_W]),
    .wdata   (s_tdata[VAL_LSB +: SAMPLE_W]),
    .re      (rd_en),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  twim_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .clip      (cfg.clip),
    .in_valid  (s_tvalid && (s_tuser == CMD_SAMPLE)),
    .sample_in ($signed(s_tdata[SAMPLE_W-1:0])),
    .in_ready  (s_tready),
    .rd_en     (rd_en),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b),
    .out       (wet),
    .out_ready (mix_ready)
  );

  twim_mix u_mix (
    .clk           (clk),
    .rst           (rst),
    .wet_gain      (cfg.wet_gain),
    .dry_gain      (cfg.dry_gain),
    .in            (wet),
    .in_ready      (mix_ready),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .shaped_sample (m_tdata)
  );

endmodule

`default_nettype wire

FILE: design/twim_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module twim_checker import twim_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [SAMPLE_W-1:0]  m_tdata,
  input logic                 psel,
  input logic                 penable,
  input logic                 pready
);

  // A result held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("output transaction changed while stalled");

  // After reset no result is pending.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  // When the output stage can move, every stage can, so input is taken.
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled although the output can drain");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    (psel && penable) |-> pready)
    else $error("configuration access not completed");

endmodule

bind table_waveshaper_interp_mix_unit twim_checker u_twim_checker (.*);

`default_nettype wire
